FILE: rtl/cfr_pkg.sv
// shared types and constants of the chunked frame reassembler
package cfr_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // result kinds
  typedef enum logic {
    KIND_COMPLETE = 1'b0,
    KIND_READ     = 1'b1
  } kind_e;

  // configuration register indexes
  typedef enum logic {
    REG_MAGIC_WORD  = 1'b0,
    REG_CHUNK_BYTES = 1'b1
  } cfg_reg_e;

  localparam int unsigned LINK_HEADER_BYTES = 24;
  localparam int unsigned CHUNK_HDR_BYTES   = 12;

  localparam logic [15:0] POS_MAX            = 16'hFFFF;
  localparam logic [31:0] MAGIC_RESET        = 32'hCAFEBABE;
  localparam logic [15:0] CHUNK_BYTES_RESET  = 16'd1000;
  localparam logic [15:0] FRAME_NUMBER_RESET = 16'd9999;

  // result of one item, handed from the parser to the output stage
  typedef struct packed {
    kind_e       kind;
    logic [15:0] frame_length;
    logic [15:0] frame_number;
    logic        rd_ok;
  } cfr_result_t;

endpackage

FILE: rtl/cfr_if.sv
// valid/ready channel interfaces for items, results and configuration writes

interface cfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic        is_data_frame;
  logic [15:0] read_address;

  modport source (
    output valid, operation, data_byte, end_of_packet, is_data_frame, read_address,
    input  ready
  );
  modport sink (
    input  valid, operation, data_byte, end_of_packet, is_data_frame, read_address,
    output ready
  );
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] frame_length;
  logic [15:0] frame_number;
  logic [7:0]  read_byte;

  modport source (
    output valid, result_kind, frame_length, frame_number, read_byte,
    input  ready
  );
  modport sink (
    input  valid, result_kind, frame_length, frame_number, read_byte,
    output ready
  );
endinterface

interface cfr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: rtl/cfr_buffer.sv
// frame buffer memory: one write port, one registered read port
module cfr_buffer #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  // byte write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/cfr_parser.sv
// packet parser: header capture, chunk checks and buffer write control
module cfr_parser #(
  parameter int unsigned BUFFER_BYTES = 65536,
  parameter int unsigned ADDR_W       = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_packet_i,
  input  logic                 is_data_frame_i,
  input  logic [15:0]          read_address_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 wr_en_o,
  output logic [ADDR_W-1:0]    wr_addr_o,
  output logic [7:0]           wr_data_o,
  output logic                 rd_en_o,
  output logic [ADDR_W-1:0]    rd_addr_o,
  output logic                 res_valid_o,
  output cfr_pkg::cfr_result_t res_o
);
  import cfr_pkg::*;

  localparam logic [15:0] HDR_START  = 16'(LINK_HEADER_BYTES);
  localparam logic [15:0] HDR_END    = 16'(LINK_HEADER_BYTES + CHUNK_HDR_BYTES);
  localparam logic [3:0]  HDR_LAST_K = 4'(CHUNK_HDR_BYTES - 1);

  logic [31:0]       magic_word_q;
  logic [15:0]       chunk_bytes_q;
  logic [15:0]       pos_q, pos_d;
  logic [31:0]       magic_q, magic_d;
  logic [63:0]       hdr_q, hdr_d;
  logic              acc_q, acc_d;
  logic [15:0]       left_q, left_d;
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [15:0]       cur_fn_q, cur_fn_d;
  logic [31:0]       prod_q;

  logic [31:0] magic_now;
  logic [63:0] hdr_now;
  logic        in_hdr, hdr_last, pkt, rd_sel;
  logic [3:0]  hdr_k;
  logic [15:0] fnum, idx, total, len;
  logic        magic_ok, chunk0, fn_ok, fits, hdr_accept, wr_ok, acc_mid, complete;
  logic [32:0] len_sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q  <= MAGIC_RESET;
      chunk_bytes_q <= CHUNK_BYTES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAGIC_WORD:  magic_word_q  <= cfg_data_i;
        REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i[15:0];
      endcase
    end
  end

  // chunk offset, index times stride, registered ahead of its use
  always_ff @(posedge clk_i) begin
    prod_q <= 32'(hdr_q[31:16]) * 32'(chunk_bytes_q);
  end

  // header byte capture
  assign in_hdr = (pos_q >= HDR_START) && (pos_q < HDR_END);
  assign hdr_k  = 4'(pos_q - HDR_START);

  always_comb begin
    magic_now = magic_q;
    hdr_now   = hdr_q;
    for (int i = 0; i < 4; i++) begin
      if (in_hdr && hdr_k == 4'(i)) magic_now[8*i +: 8] = data_byte_i;
    end
    for (int i = 0; i < 8; i++) begin
      if (in_hdr && hdr_k == 4'(i + 4)) hdr_now[8*i +: 8] = data_byte_i;
    end
  end

  assign fnum  = hdr_now[15:0];
  assign idx   = hdr_now[31:16];
  assign total = hdr_now[47:32];
  assign len   = hdr_now[63:48];

  // chunk checks
  assign pkt        = fire_i && (operation_i == OP_PACKET);
  assign rd_sel     = fire_i && (operation_i == OP_READ);
  assign hdr_last   = in_hdr && (hdr_k == HDR_LAST_K);
  assign magic_ok   = (magic_now == magic_word_q);
  assign chunk0     = (idx == 16'd0);
  assign fn_ok      = chunk0 || (fnum == cur_fn_q);
  assign len_sum    = {1'b0, prod_q} + 33'(len);
  assign fits       = (len_sum < 33'(BUFFER_BYTES));
  assign hdr_accept = magic_ok && fn_ok && fits;
  assign wr_ok      = (pos_q >= HDR_END) && (pos_q != POS_MAX) && acc_q && (left_q != 16'd0);
  assign acc_mid    = hdr_last ? hdr_accept : acc_q;
  assign complete   = end_of_packet_i && is_data_frame_i && acc_mid && (total != 16'd0) &&
                      (idx == total - 16'd1);

  // parser next state
  always_comb begin
    pos_d    = pos_q;
    magic_d  = magic_q;
    hdr_d    = hdr_q;
    acc_d    = acc_q;
    left_d   = left_q;
    wptr_d   = wptr_q;
    cur_fn_d = cur_fn_q;
    if (pkt) begin
      if (!is_data_frame_i) begin
        acc_d = 1'b0;
        pos_d = POS_MAX;
      end else begin
        magic_d = magic_now;
        hdr_d   = hdr_now;
        if (hdr_last) begin
          acc_d = hdr_accept;
          if (magic_ok && chunk0) cur_fn_d = fnum;
          if (hdr_accept) begin
            wptr_d = ADDR_W'(prod_q);
            left_d = len;
          end
        end else if (wr_ok) begin
          wptr_d = wptr_q + ADDR_W'(1);
          left_d = left_q - 16'd1;
        end
        if (pos_q != POS_MAX) pos_d = pos_q + 16'd1;
      end
      if (end_of_packet_i) begin
        pos_d = 16'd0;
        acc_d = 1'b0;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 16'd0;
      magic_q  <= 32'd0;
      hdr_q    <= 64'd0;
      acc_q    <= 1'b0;
      left_q   <= 16'd0;
      wptr_q   <= '0;
      cur_fn_q <= FRAME_NUMBER_RESET;
    end else begin
      pos_q    <= pos_d;
      magic_q  <= magic_d;
      hdr_q    <= hdr_d;
      acc_q    <= acc_d;
      left_q   <= left_d;
      wptr_q   <= wptr_d;
      cur_fn_q <= cur_fn_d;
    end
  end

  // buffer access
  assign wr_en_o   = pkt && is_data_frame_i && !hdr_last && wr_ok;
  assign wr_addr_o = wptr_q;
  assign wr_data_o = data_byte_i;
  assign rd_en_o   = rd_sel;
  assign rd_addr_o = ADDR_W'(read_address_i);

  // result of this item, a release item gives none
  assign res_valid_o        = rd_sel || (pkt && complete);
  assign res_o.kind         = rd_sel ? KIND_READ : KIND_COMPLETE;
  assign res_o.frame_length = rd_sel ? 16'd0 : len_sum[15:0];
  assign res_o.frame_number = rd_sel ? 16'd0 : cur_fn_d;
  assign res_o.rd_ok        = rd_sel && (32'(read_address_i) < 32'(BUFFER_BYTES));

endmodule

FILE: rtl/cfr_outq.sv
// result pipeline: memory read stage and output register
module cfr_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  cfr_pkg::cfr_result_t res_i,
  input  logic [7:0]           rd_data_i,
  output logic                 can_accept_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 result_kind_o,
  output logic [15:0]          frame_length_o,
  output logic [15:0]          frame_number_o,
  output logic [7:0]           read_byte_o
);
  import cfr_pkg::*;

  logic        p1_valid_q;
  cfr_result_t p1_q;
  logic        out_valid_q;
  logic        kind_q;
  logic [15:0] len_q, fn_q;
  logic [7:0]  byte_q;
  logic        adv;

  // stage one moves on when the output register is free or being taken
  assign adv          = p1_valid_q && (!out_valid_q || out_ready_i);
  assign can_accept_o = !p1_valid_q || adv;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= res_valid_i || (p1_valid_q && !adv);
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, read data joins the item as it leaves stage one
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      p1_q <= res_i;
    end
    if (adv) begin
      kind_q <= p1_q.kind;
      len_q  <= p1_q.frame_length;
      fn_q   <= p1_q.frame_number;
      byte_q <= p1_q.rd_ok ? rd_data_i : 8'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign frame_length_o = len_q;
  assign frame_number_o = fn_q;
  assign read_byte_o    = byte_q;

endmodule

FILE: rtl/chunked_frame_reassembler.sv
// top level of the chunked frame reassembler
// result path: stage one with the buffer read, then the output register, which can stall
// throughput: one item per cycle while the result pipeline can accept, at most one buffer write or read each
// reset: parser state cleared, current frame number 9999, registers to defaults
// the frame buffer keeps its contents through reset and has no clearing pass
module chunked_frame_reassembler #(
  parameter int unsigned BUFFER_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfr_in_if.sink            in_i,
  cfr_out_if.source         out_o,
  cfr_cfg_if.sink           cfg_i
);
  import cfr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);

  logic              in_fire;
  logic              can_accept;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic              res_valid;
  cfr_result_t       res;

  assign in_i.ready  = can_accept;
  assign in_fire     = in_i.valid && can_accept;
  assign cfg_i.ready = 1'b1;

  // header parsing and chunk control
  cfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .ADDR_W      (ADDR_W)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .operation_i    (in_i.operation),
    .data_byte_i    (in_i.data_byte),
    .end_of_packet_i(in_i.end_of_packet),
    .is_data_frame_i(in_i.is_data_frame),
    .read_address_i (in_i.read_address),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // frame buffer
  cfr_buffer #(
    .DEPTH (BUFFER_BYTES),
    .ADDR_W(ADDR_W)
  ) u_buffer (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // result pipeline
  cfr_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .rd_data_i     (rd_data),
    .can_accept_o  (can_accept),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .result_kind_o (out_o.result_kind),
    .frame_length_o(out_o.frame_length),
    .frame_number_o(out_o.frame_number),
    .read_byte_o   (out_o.read_byte)
  );

`ifndef NO_ASSERTIONS
  // buffer writes only come from an accepted packet byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (in_fire && in_i.operation == OP_PACKET && in_i.is_data_frame))
    else $error("buffer write without an accepted data byte");

  // a result is only produced by an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_fire)
    else $error("result raised without an accepted item");

  // frame completion only on the last byte of a data packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_COMPLETE) |->
      (in_i.end_of_packet && in_i.is_data_frame && in_i.operation == OP_PACKET))
    else $error("frame completion away from end of packet");

  // an output item appears only after its result was produced and passed stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(res_valid) || $past(res_valid, 2)))
    else $error("output valid rose without a pending result");
`endif

endmodule

FILE: sim/cfr_checker.sv
// checker of the chunked frame reassembler: watches the channels, predicts results, compares
`timescale 1ns / 100ps

module cfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfr_in_if           in_i,
  cfr_out_if          out_i,
  cfr_cfg_if          cfg_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import cfr_pkg::*;

  localparam int unsigned BUF_BYTES = 65536;
  localparam int unsigned HDR_END   = LINK_HEADER_BYTES + CHUNK_HDR_BYTES;

  // one result on the output channel
  typedef struct packed {
    kind_e       kind;
    logic [15:0] frame_length;
    logic [15:0] frame_number;
    logic [7:0]  read_byte;
  } frame_event_t;

  // register copies
  logic [31:0] cfg_magic;
  logic [15:0] cfg_stride;

  // parser and frame state
  logic [15:0] pos;
  logic [31:0] magic_cap;
  logic [63:0] hdr;        // frame 15:0, index 31:16, total 47:32, length 63:48
  logic        hdr_ok;
  logic [15:0] left;
  logic [31:0] wr_ptr;
  logic [15:0] cur_frame;
  logic [15:0] asm_len;
  logic        rdy_flag;   // not visible on the result channel
  logic [7:0]  frame_mem [BUF_BYTES];

  frame_event_t expected_results[$];
  int unsigned  mismatch_count = 0;

  // header complete: decide whether the chunk payload is stored
  task automatic finish_header();
    logic [15:0] fnum;
    logic [15:0] idx;
    logic [15:0] len;
    logic [31:0] offset;
    fnum   = hdr[15:0];
    idx    = hdr[31:16];
    len    = hdr[63:48];
    hdr_ok = 1'b0;
    if (magic_cap == cfg_magic) begin
      // chunk 0 restarts the frame, even when it is dropped afterwards
      if (idx == 16'd0) begin
        asm_len   = 16'd0;
        cur_frame = fnum;
      end
      if (fnum == cur_frame) begin
        offset = 32'(idx) * 32'(cfg_stride);
        if (33'(offset) + 33'(len) < 33'(BUF_BYTES)) begin
          hdr_ok = 1'b1;
          wr_ptr = offset;
          left   = len;
        end
      end
    end
  endtask

  // one packet byte through the parser
  task automatic take_packet_byte(input logic [7:0] b, input logic eop, input logic is_data);
    int unsigned  k;
    logic [15:0]  idx;
    logic [15:0]  total;
    logic [31:0]  offset;
    frame_event_t ev;
    if (!is_data) begin
      // rest of the packet is dropped
      hdr_ok = 1'b0;
      pos    = POS_MAX;
    end else if (pos >= LINK_HEADER_BYTES && pos < HDR_END) begin
      k = pos - LINK_HEADER_BYTES;
      if (k < 4) magic_cap[8*k +: 8] = b;
      else hdr[8*(k-4) +: 8] = b;
      if (k == CHUNK_HDR_BYTES - 1) finish_header();
    end else if (pos >= HDR_END && pos != POS_MAX && hdr_ok && left != 16'd0) begin
      if (wr_ptr < BUF_BYTES) frame_mem[wr_ptr[15:0]] = b;
      wr_ptr = wr_ptr + 32'd1;
      left   = left - 16'd1;
    end

    if (is_data && pos < POS_MAX) pos = pos + 16'd1;

    // end of packet: last chunk completes the frame
    if (eop) begin
      idx   = hdr[31:16];
      total = hdr[47:32];
      if (is_data && hdr_ok && total != 16'd0 && idx == total - 16'd1) begin
        offset          = 32'(idx) * 32'(cfg_stride);
        asm_len         = offset[15:0] + hdr[63:48];
        rdy_flag        = 1'b1;
        ev.kind         = KIND_COMPLETE;
        ev.frame_length = asm_len;
        ev.frame_number = cur_frame;
        ev.read_byte    = 8'd0;
        expected_results.push_back(ev);
      end
      pos    = 16'd0;
      hdr_ok = 1'b0;
    end
  endtask

  // one accepted input item
  task automatic reassemble_item();
    frame_event_t ev;
    case (in_i.operation)
      OP_PACKET: take_packet_byte(in_i.data_byte, in_i.end_of_packet, in_i.is_data_frame);
      OP_READ: begin
        ev.kind         = KIND_READ;
        ev.frame_length = 16'd0;
        ev.frame_number = 16'd0;
        ev.read_byte    = frame_mem[in_i.read_address];
        expected_results.push_back(ev);
      end
      OP_RELEASE: rdy_flag = 1'b0;
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // one accepted result against the oldest expectation
  task automatic compare_result();
    frame_event_t ev;
    if (expected_results.size() == 0) begin
      $error("result_kind: expected no result, got %0d", out_i.result_kind);
      mismatch_count++;
    end else begin
      ev = expected_results.pop_front();
      check_field("result_kind", 16'(ev.kind), 16'(out_i.result_kind));
      check_field("frame_length", ev.frame_length, out_i.frame_length);
      check_field("frame_number", ev.frame_number, out_i.frame_number);
      check_field("read_byte", 16'(ev.read_byte), 16'(out_i.read_byte));
    end
  endtask

  // results are compared before the same edge's item is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_magic  = MAGIC_RESET;
      cfg_stride = CHUNK_BYTES_RESET;
      pos        = 16'd0;
      magic_cap  = 32'd0;
      hdr        = 64'd0;
      hdr_ok     = 1'b0;
      left       = 16'd0;
      wr_ptr     = 32'd0;
      cur_frame  = FRAME_NUMBER_RESET;
      asm_len    = 16'd0;
      rdy_flag   = 1'b0;
      expected_results.delete();
    end else begin
      if (out_i.valid && out_i.ready) compare_result();
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_MAGIC_WORD) cfg_magic = cfg_i.data;
        else cfg_stride = cfg_i.data[15:0];
      end
      if (in_i.valid && in_i.ready) reassemble_item();
    end
    pending_o = expected_results.size();
    errors_o  = mismatch_count;
  end

endmodule

FILE: sim/tb_chunked_frame_reassembler.sv
// testbench top of the chunked frame reassembler: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_chunked_frame_reassembler;
  import cfr_pkg::*;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned LONG_FILL  = 65499;  // buffer bytes filled by the long packet
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned TIMEOUT_NS = 5_000_000;

  logic clk;
  logic rst_n;

  cfr_in_if  in_if();
  cfr_out_if out_if();
  cfr_cfg_if cfg_if();

  int unsigned pending;
  int unsigned errors;

  chunked_frame_reassembler dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfr_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_i     (out_if),
    .cfg_i     (cfg_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  // stimulus state
  logic [7:0]  pkt[$];
  logic [31:0] magic_now;
  logic [15:0] stride_now;
  logic [15:0] frame_no;
  logic [31:0] near_addr;
  int unsigned items_sent;
  bit          no_idle;
  bit          stall_on;
  bit          mix_ops;

  // result-side stall state
  int unsigned hold;
  int unsigned stall_pick;
  bit          level;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_chunked_frame_reassembler: FAIL");
    $finish;
  end

  // result ready: runs of ready, short stalls and a few long ones
  initial begin
    out_if.ready = 1'b0;
    hold = 0;
    level = 1'b1;
    forever begin
      @(negedge clk);
      if (!stall_on) begin
        out_if.ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          stall_pick = $urandom_range(0, 99);
          if (stall_pick < 60) begin
            level = 1'b1;
            hold  = $urandom_range(1, 8);
          end else if (stall_pick < 96) begin
            level = 1'b0;
            hold  = $urandom_range(1, 3);
          end else begin
            level = 1'b0;
            hold  = $urandom_range(15, 60);
          end
        end
        out_if.ready <= level;
        hold--;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // reads stay inside bytes that are known to hold data
  function automatic logic [15:0] pick_read_addr();
    logic [31:0] a;
    a = near_addr + $urandom_range(0, 15);
    if ($urandom_range(0, 1) == 0 && a < LONG_FILL) return a[15:0];
    return 16'($urandom_range(0, LONG_FILL - 1));
  endfunction

  // one item; called and returning at a falling edge, valid left high
  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic eop,
                           input logic is_data, input logic [15:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.data_byte     <= b;
    in_if.end_of_packet <= eop;
    in_if.is_data_frame <= is_data;
    in_if.read_address  <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // read, release or unused operation with random filler fields
  task automatic send_other(input logic [1:0] op, input logic [15:0] addr);
    send_item(op, 8'($urandom), 1'($urandom), 1'($urandom), addr);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop, input logic is_data);
    int unsigned r;
    if (mix_ops) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_other(OP_READ, pick_read_addr());
      else if (r < 7) send_other(OP_RELEASE, 16'($urandom));
      else if (r < 8) send_other(OP_UNUSED, 16'($urandom));
    end
    send_item(OP_PACKET, b, eop, is_data, 16'($urandom));
  endtask

  // link header, little-endian chunk header and payload
  task automatic build_chunk(input logic [31:0] magic, input logic [15:0] fnum,
                             input logic [15:0] idx, input logic [15:0] total,
                             input logic [15:0] len, input int unsigned payload_n);
    logic [63:0] fields;
    fields = {len, total, idx, fnum};
    pkt.delete();
    repeat (LINK_HEADER_BYTES) pkt.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) pkt.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 8; i++) pkt.push_back(fields[8*i +: 8]);
    repeat (payload_n) pkt.push_back(8'($urandom));
    near_addr = 32'(idx) * 32'(stride_now);
  endtask

  task automatic truncate_pkt(input int unsigned n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  // sends the built packet; the byte at nondata_at is marked non-data, later ones at random
  task automatic send_pkt(input int nondata_at);
    int  n;
    logic d;
    n = pkt.size();
    for (int i = 0; i < n; i++) begin
      if (nondata_at < 0 || i < nondata_at) d = 1'b1;
      else if (i == nondata_at) d = 1'b0;
      else d = 1'($urandom);
      send_byte(pkt[i], i == n - 1, d);
    end
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] magic, input logic [15:0] stride);
    write_reg(REG_MAGIC_WORD, magic);
    write_reg(REG_CHUNK_BYTES, {16'($urandom), stride});
    cfg_if.valid <= 1'b0;
    magic_now  = magic;
    stride_now = stride;
  endtask

  // chunks of one frame, mostly well formed, some with a broken field
  task automatic random_frame();
    int unsigned total;
    int unsigned nchunks;
    int unsigned len;
    int unsigned payload;
    logic [31:0] magic;
    logic [15:0] fnum;
    logic [15:0] idx;
    total = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    if ($urandom_range(0, 4) != 0) frame_no = 16'($urandom);
    nchunks = (total == 0) ? 1 : total;
    for (int c = 0; c < nchunks; c++) begin
      magic   = ($urandom_range(0, 19) == 0) ? 32'($urandom) : magic_now;
      fnum    = ($urandom_range(0, 14) == 0) ? 16'($urandom) : frame_no;
      idx     = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 5)) : 16'(c);
      len     = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
      payload = ($urandom_range(0, 9) < 7) ? len : $urandom_range(0, len + 4);
      build_chunk(magic, fnum, idx, 16'(total), 16'(len), payload);
      if ($urandom_range(0, 19) == 0) truncate_pkt($urandom_range(1, 35));
      send_pkt(($urandom_range(0, 14) == 0) ? int'($urandom_range(0, pkt.size() - 1)) : -1);
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop;
    int unsigned r;
    stop    = items_sent + n;
    mix_ops = 1'b1;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // switch between stretches with and without idling
        if ($urandom_range(0, 2) == 0) begin
          no_idle  = 1'b1;
          stall_on = 1'b0;
        end else begin
          no_idle  = 1'b0;
          stall_on = 1'b1;
        end
      end else if (r < 10) begin
        drain();
      end else if (r < 72) begin
        random_frame();
      end else if (r < 84) begin
        // noise packet
        pkt.delete();
        repeat ($urandom_range(1, 50)) pkt.push_back(8'($urandom));
        send_pkt(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, pkt.size() - 1)) : -1);
      end else if (r < 92) begin
        // packet cut inside the headers
        build_chunk(magic_now, frame_no, 16'd0, 16'd1, 16'($urandom_range(0, 12)), 0);
        truncate_pkt($urandom_range(1, 35));
        send_pkt(-1);
      end else begin
        repeat ($urandom_range(1, 6)) send_other(OP_READ, pick_read_addr());
      end
    end
    mix_ops  = 1'b0;
    no_idle  = 1'b0;
    stall_on = 1'b1;
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.operation     = OP_PACKET;
    in_if.data_byte     = 8'd0;
    in_if.end_of_packet = 1'b0;
    in_if.is_data_frame = 1'b0;
    in_if.read_address  = 16'd0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_MAGIC_WORD;
    cfg_if.data         = 32'd0;
    magic_now           = MAGIC_RESET;
    stride_now          = CHUNK_BYTES_RESET;
    frame_no            = 16'd1;
    near_addr           = 32'd0;
    items_sent          = 0;
    mix_ops             = 1'b0;
    no_idle             = 1'b1;
    stall_on            = 1'b0;
    rst_n               = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // long packet: fills most of the buffer, byte position saturates, tail dropped
    build_chunk(MAGIC_RESET, frame_no, 16'd0, 16'd1, POS_MAX, LONG_FILL + 5);
    send_pkt(-1);
    drain();
    no_idle  = 1'b0;
    stall_on = 1'b1;
    send_other(OP_READ, 16'd0);
    send_other(OP_READ, 16'(LONG_FILL - 1));

    // packet ends inside the chunk header
    build_chunk(MAGIC_RESET, 16'd7, 16'd0, 16'd1, 16'd4, 4);
    truncate_pkt(30);
    send_pkt(-1);

    // header alone ends the packet and completes an empty frame
    build_chunk(MAGIC_RESET, 16'd42, 16'd0, 16'd1, 16'd0, 0);
    send_pkt(-1);

    // three-chunk frame with a short chunk and rejected chunks in between
    build_chunk(MAGIC_RESET, 16'hFFFF, 16'd0, 16'd3, 16'd5, 5);
    send_pkt(-1);
    build_chunk(MAGIC_RESET, 16'hFFFF, 16'd1, 16'd3, 16'd6, 3);
    send_pkt(-1);
    build_chunk(~MAGIC_RESET, 16'hFFFF, 16'd2, 16'd3, 16'd4, 4);
    send_pkt(-1);
    build_chunk(MAGIC_RESET, 16'h0000, 16'd2, 16'd3, 16'd4, 4);
    send_pkt(-1);
    build_chunk(MAGIC_RESET, 16'hFFFF, 16'd70, 16'd71, 16'd10, 10);
    send_pkt(-1);
    build_chunk(MAGIC_RESET, 16'hFFFF, 16'd2, 16'd3, 16'd4, 8);
    send_pkt(-1);
    send_other(OP_READ, 16'd1002);
    send_other(OP_READ, 16'd2003);
    send_other(OP_READ, 16'd2004);
    send_other(OP_RELEASE, 16'hFFFF);
    send_other(OP_UNUSED, 16'h5A5A);

    // zero total chunks never completes
    build_chunk(MAGIC_RESET, 16'd9, 16'd0, 16'd0, 16'd3, 3);
    send_pkt(-1);

    // non-data byte inside the chunk header
    build_chunk(MAGIC_RESET, 16'd9, 16'd0, 16'd1, 16'd4, 4);
    send_pkt(30);

    // chunk 0 with a wrong magic keeps frame 9, whose last chunk then completes
    build_chunk(~MAGIC_RESET, 16'd77, 16'd0, 16'd2, 16'd2, 2);
    send_pkt(-1);
    build_chunk(MAGIC_RESET, 16'd9, 16'd1, 16'd2, 16'd2, 2);
    send_pkt(-1);
    send_other(OP_READ, 16'd1001);
    drain();

    // random traffic under several register settings
    configure(32'h0000_0000, 16'd1);
    random_phase(330);
    drain();
    configure(32'hFFFF_FFFF, 16'hFFFF);
    random_phase(330);
    drain();
    configure(32'($urandom), 16'($urandom_range(2, 3000)));
    random_phase(330);
    drain();

    if (errors == 0) $display("tb_chunked_frame_reassembler: PASS");
    else $display("tb_chunked_frame_reassembler: FAIL");
    $finish;
  end

endmodule
